FILE: sv/pid_chained_hash_map_macros.svh
// ----------------------------------------------------------------------------
// pid_chained_hash_map assertion macros
// Shorthand for the concurrent checks used in the hash map RTL.
// ----------------------------------------------------------------------------
`ifndef PID_CHAINED_HASH_MAP_MACROS_SVH
`define PID_CHAINED_HASH_MAP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PHM_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PHM_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/phm_pkg.sv
// ----------------------------------------------------------------------------
// phm_pkg
// Shared field widths, codes and types of the process-id hash map.
// ----------------------------------------------------------------------------
`default_nettype none

package phm_pkg;

    localparam int KIND_W   = 2;
    localparam int KEY_W    = 23;
    localparam int VALUE_W  = 8;
    localparam int STATUS_W = 2;
    localparam int HASH_W   = 32;

    localparam logic [HASH_W-1:0] HASH_MULT = 32'd2654435761;

    typedef enum logic [KIND_W-1:0] {
        KIND_LOOKUP = 2'd0,
        KIND_INSERT = 2'd1,
        KIND_REMOVE = 2'd2,
        KIND_CLEAR  = 2'd3
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_LINK,
        S_WALK,
        S_RESP
    } t_state;

    // Write enables of the entry pool: key, value and link together, or link alone.
    typedef struct packed {
        logic fields;
        logic link;
    } t_pool_we;

endpackage

`default_nettype wire

FILE: sv/phm_req_if.sv
// ----------------------------------------------------------------------------
// phm_req_if
// Request channel: one operation beat with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface phm_req_if;

    logic                         valid;
    logic                         ready;
    logic [phm_pkg::KIND_W-1:0]   kind;
    logic [phm_pkg::KEY_W-1:0]    key;
    logic [phm_pkg::VALUE_W-1:0]  value;

    modport source (output valid, output kind, output key, output value, input ready);
    modport sink   (input valid, input kind, input key, input value, output ready);

endinterface

`default_nettype wire

FILE: sv/phm_rsp_if.sv
// ----------------------------------------------------------------------------
// phm_rsp_if
// Response channel: one result beat with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface phm_rsp_if;

    logic                          valid;
    logic                          ready;
    logic [phm_pkg::STATUS_W-1:0]  status;
    logic [phm_pkg::VALUE_W-1:0]   found_value;

    modport source (output valid, output status, output found_value, input ready);
    modport sink   (input valid, input status, input found_value, output ready);

endinterface

`default_nettype wire

FILE: sv/phm_hash.sv
// ----------------------------------------------------------------------------
// phm_hash
// Multiplicative hash followed by the remainder by the bucket count, worked out
// by reciprocal multiplication on one shared multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module phm_hash #(
    parameter int BUCKETS = 256,
    parameter int BW      = 8
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic [phm_pkg::KEY_W-1:0]  i_key,
    output logic                            o_done,
    output logic [BW-1:0]                   o_bucket
);
    import phm_pkg::*;

    localparam int HW2 = 2 * HASH_W;

    // floor(2^32 / BUCKETS): the quotient estimate it gives is the true
    // quotient or one below it, so one compare and subtract finishes the job.
    localparam logic [HASH_W-1:0] RECIP   = HASH_W'((64'd1 << HASH_W) / 64'(BUCKETS));
    localparam logic [HASH_W-1:0] DIVISOR = HASH_W'(BUCKETS);

    localparam logic [1:0] STEP_QUOT = 2'd0;
    localparam logic [1:0] STEP_REM  = 2'd1;

    logic              r_busy;
    logic              r_done;
    logic [1:0]        r_step;
    logic [HASH_W-1:0] r_prod;
    logic [HASH_W-1:0] r_quot;
    logic [HASH_W-1:0] r_rem;

    logic [HASH_W-1:0] w_mul_a;
    logic [HASH_W-1:0] w_mul_b;
    logic [HW2-1:0]    w_mul;

    // Operand selection of the shared multiplier: key times the hash constant
    // at start, product times the reciprocal next, then quotient times buckets.
    always_comb begin
        w_mul_a = r_prod;
        w_mul_b = RECIP;
        if (i_start) begin
            w_mul_a = HASH_W'(i_key);
            w_mul_b = HASH_MULT;
        end else if (r_step == STEP_REM) begin
            w_mul_a = r_quot;
            w_mul_b = DIVISOR;
        end
    end

    assign w_mul = HW2'(w_mul_a) * HW2'(w_mul_b);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= STEP_QUOT;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= STEP_QUOT;
                r_prod <= w_mul[HASH_W-1:0];
            end else if (r_busy) begin
                r_step <= r_step + 2'd1;
                case (r_step)
                    STEP_QUOT: begin
                        r_quot <= w_mul[HW2-1:HASH_W];
                    end
                    STEP_REM: begin
                        r_rem <= r_prod - w_mul[HASH_W-1:0];
                    end
                    default: begin
                        if (r_rem >= DIVISOR) begin
                            r_rem <= r_rem - DIVISOR;
                        end
                        r_busy <= 1'b0;
                        r_done <= 1'b1;
                    end
                endcase
            end
        end
    end

    assign o_done   = r_done;
    assign o_bucket = r_rem[BW-1:0];

endmodule

`default_nettype wire

FILE: sv/phm_head_mem.sv
// ----------------------------------------------------------------------------
// phm_head_mem
// Bucket head store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module phm_head_mem #(
    parameter int DEPTH = 256,
    parameter int AW    = 8,
    parameter int DW    = 9
) (
    input  wire logic           i_clk,
    input  wire logic           i_we,
    input  wire logic [AW-1:0]  i_waddr,
    input  wire logic [DW-1:0]  i_wdata,
    input  wire logic [AW-1:0]  i_raddr,
    output logic [DW-1:0]       o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: sv/phm_pool_mem.sv
// ----------------------------------------------------------------------------
// phm_pool_mem
// Entry pool: key, value and chain link per entry, one write and one read port.
// ----------------------------------------------------------------------------
`default_nettype none

module phm_pool_mem #(
    parameter int DEPTH = 256,
    parameter int AW    = 8,
    parameter int LW    = 9
) (
    input  wire logic                         i_clk,
    input  wire phm_pkg::t_pool_we            i_we,
    input  wire logic [AW-1:0]                i_waddr,
    input  wire logic [phm_pkg::KEY_W-1:0]    i_key,
    input  wire logic [phm_pkg::VALUE_W-1:0]  i_value,
    input  wire logic [LW-1:0]                i_link,
    input  wire logic [AW-1:0]                i_raddr,
    output logic [phm_pkg::KEY_W-1:0]         o_key,
    output logic [phm_pkg::VALUE_W-1:0]       o_value,
    output logic [LW-1:0]                     o_link
);
    import phm_pkg::*;

    logic [KEY_W-1:0]   r_keys   [DEPTH];
    logic [VALUE_W-1:0] r_values [DEPTH];
    logic [LW-1:0]      r_links  [DEPTH];

    logic [KEY_W-1:0]   r_key_q;
    logic [VALUE_W-1:0] r_value_q;
    logic [LW-1:0]      r_link_q;

    always_ff @(posedge i_clk) begin
        if (i_we.fields) begin
            r_keys[i_waddr]   <= i_key;
            r_values[i_waddr] <= i_value;
        end
        if (i_we.fields || i_we.link) begin
            r_links[i_waddr] <= i_link;
        end
        r_key_q   <= r_keys[i_raddr];
        r_value_q <= r_values[i_raddr];
        r_link_q  <= r_links[i_raddr];
    end

    assign o_key   = r_key_q;
    assign o_value = r_value_q;
    assign o_link  = r_link_q;

endmodule

`default_nettype wire

FILE: sv/pid_chained_hash_map.sv
// ----------------------------------------------------------------------------
// pid_chained_hash_map: process-id to slot-index chained hash table.
// Flow to the response beat: insert hashes the key on the shared multiplier, then links
// the new entry (not when the pool is full); lookup and remove hash, read the chain head,
// then visit one chain entry per pool read; clear sweeps every bucket.
// Throughput: one item at a time, taken in the cycle after the previous result is loaded.
// Reset: a sweep marks every bucket empty; no request before.
// ----------------------------------------------------------------------------
`default_nettype none
`include "pid_chained_hash_map_macros.svh"

module pid_chained_hash_map #(
    parameter int BUCKETS      = 256,
    parameter int POOL_ENTRIES = 256
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    phm_req_if.sink    i_req,
    phm_rsp_if.source  o_rsp
);
    import phm_pkg::*;

    // Bucket index, pool index, and link/fill widths. A link or head holding
    // POOL_ENTRIES (or more) means "no entry".
    localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int PW = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;
    localparam int LW = $clog2(POOL_ENTRIES + 1);

    localparam logic [LW-1:0] EMPTY      = LW'(POOL_ENTRIES);
    localparam logic [BW-1:0] SWEEP_LAST = BW'(BUCKETS - 1);

    // ------------------------------------------------------------------
    // Sequencer state and operation registers
    // ------------------------------------------------------------------
    t_state              r_state;
    t_state              n_state;
    t_kind               r_kind;
    logic [KEY_W-1:0]    r_key;
    logic [VALUE_W-1:0]  r_value;
    logic                r_op_live;
    logic [BW-1:0]       r_sweep;
    logic [LW-1:0]       r_fill;
    logic [PW-1:0]       r_cur;
    logic [PW-1:0]       r_prev;
    logic                r_prev_valid;
    t_status             r_res_status;
    logic [VALUE_W-1:0]  r_res_found;

    // Output register, so a waiting result still lets the next request be taken.
    logic                r_out_valid;
    t_status             r_status;
    logic [VALUE_W-1:0]  r_found;

    // ------------------------------------------------------------------
    // Datapath wires
    // ------------------------------------------------------------------
    logic                w_accept;
    logic                w_hash_start;
    logic                w_hash_done;
    logic [BW-1:0]       w_bucket;

    logic                w_head_we;
    logic [BW-1:0]       w_head_waddr;
    logic [LW-1:0]       w_head_wdata;
    logic [LW-1:0]       w_head_q;

    t_pool_we            w_pool_we;
    logic [PW-1:0]       w_pool_waddr;
    logic [LW-1:0]       w_pool_link;
    logic [PW-1:0]       w_pool_raddr;
    logic [KEY_W-1:0]    w_pool_key_q;
    logic [VALUE_W-1:0]  w_pool_value_q;
    logic [LW-1:0]       w_pool_link_q;

    logic                w_pool_full;
    logic                w_head_empty;
    logic                w_link_empty;
    logic                w_match;
    logic                w_rsp_load;

    assign w_pool_full  = (r_fill >= EMPTY);
    assign w_head_empty = (w_head_q >= EMPTY);
    assign w_link_empty = (w_pool_link_q >= EMPTY);
    assign w_match      = (w_pool_key_q == r_key);
    assign w_accept     = i_req.valid && i_req.ready;

    // ------------------------------------------------------------------
    // Shared hash unit and the two stores
    // ------------------------------------------------------------------
    phm_hash #(
        .BUCKETS (BUCKETS),
        .BW      (BW)
    ) u_hash (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_hash_start),
        .i_key    (i_req.key),
        .o_done   (w_hash_done),
        .o_bucket (w_bucket)
    );

    // The bucket address is read every cycle; once the hash finishes, the
    // head of the chain is there in the cycle after.
    phm_head_mem #(
        .DEPTH (BUCKETS),
        .AW    (BW),
        .DW    (LW)
    ) u_head_mem (
        .i_clk   (i_clk),
        .i_we    (w_head_we),
        .i_waddr (w_head_waddr),
        .i_wdata (w_head_wdata),
        .i_raddr (w_bucket),
        .o_rdata (w_head_q)
    );

    phm_pool_mem #(
        .DEPTH (POOL_ENTRIES),
        .AW    (PW),
        .LW    (LW)
    ) u_pool_mem (
        .i_clk   (i_clk),
        .i_we    (w_pool_we),
        .i_waddr (w_pool_waddr),
        .i_key   (r_key),
        .i_value (r_value),
        .i_link  (w_pool_link),
        .i_raddr (w_pool_raddr),
        .o_key   (w_pool_key_q),
        .o_value (w_pool_value_q),
        .o_link  (w_pool_link_q)
    );

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_sweep == SWEEP_LAST) begin
                    n_state = r_op_live ? S_RESP : S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    n_state = (t_kind'(i_req.kind) == KIND_CLEAR) ? S_CLEAR : S_HASH;
                end
            end
            S_HASH: begin
                if (w_hash_done) begin
                    n_state = (r_kind == KIND_INSERT && w_pool_full) ? S_RESP : S_LINK;
                end
            end
            S_LINK: begin
                if (r_kind == KIND_INSERT || w_head_empty) begin
                    n_state = S_RESP;
                end else begin
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                if (w_match || w_link_empty) begin
                    n_state = S_RESP;
                end
            end
            S_RESP: begin
                if (w_rsp_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Control outputs of the sequencer
    // ------------------------------------------------------------------
    always_comb begin
        i_req.ready  = 1'b0;
        w_hash_start = 1'b0;
        w_head_we    = 1'b0;
        w_head_waddr = w_bucket;
        w_head_wdata = w_pool_link_q;
        w_pool_we    = '0;
        w_pool_waddr = r_prev;
        w_pool_link  = w_pool_link_q;
        w_pool_raddr = r_cur;
        w_rsp_load   = 1'b0;
        case (r_state)
            S_CLEAR: begin
                w_head_we    = 1'b1;
                w_head_waddr = r_sweep;
                w_head_wdata = EMPTY;
            end
            S_IDLE: begin
                i_req.ready  = 1'b1;
                w_hash_start = i_req.valid && (t_kind'(i_req.kind) != KIND_CLEAR);
            end
            S_HASH: begin
            end
            S_LINK: begin
                if (r_kind == KIND_INSERT) begin
                    // New entry goes at the head of its chain.
                    w_pool_we.fields = 1'b1;
                    w_pool_waddr     = r_fill[PW-1:0];
                    w_pool_link      = w_head_q;
                    w_head_we        = 1'b1;
                    w_head_wdata     = r_fill;
                end else begin
                    w_pool_raddr = w_head_q[PW-1:0];
                end
            end
            S_WALK: begin
                if (w_match) begin
                    if (r_kind == KIND_REMOVE) begin
                        // Unlink: the predecessor (or the head) skips this entry.
                        if (r_prev_valid) begin
                            w_pool_we.link = 1'b1;
                        end else begin
                            w_head_we = 1'b1;
                        end
                    end
                end else begin
                    w_pool_raddr = w_pool_link_q[PW-1:0];
                end
            end
            S_RESP: begin
                w_rsp_load = !r_out_valid || o_rsp.ready;
            end
            default: begin
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_sweep     <= '0;
            r_fill      <= '0;
            r_op_live   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            if (w_accept) begin
                r_kind       <= t_kind'(i_req.kind);
                r_key        <= i_req.key;
                r_value      <= i_req.value;
                r_res_status <= ST_OK;
                r_res_found  <= '0;
                r_op_live    <= 1'b1;
                if (t_kind'(i_req.kind) == KIND_CLEAR) begin
                    r_fill  <= '0;
                    r_sweep <= '0;
                end
            end

            if (r_state == S_CLEAR) begin
                r_sweep <= r_sweep + BW'(1);
            end

            if (r_state == S_HASH && w_hash_done && r_kind == KIND_INSERT && w_pool_full) begin
                r_res_status <= ST_FULL;
            end

            if (r_state == S_LINK) begin
                if (r_kind == KIND_INSERT) begin
                    r_fill <= r_fill + LW'(1);
                end else if (w_head_empty) begin
                    r_res_status <= ST_MISS;
                end else begin
                    r_cur        <= w_head_q[PW-1:0];
                    r_prev_valid <= 1'b0;
                end
            end

            if (r_state == S_WALK) begin
                if (w_match) begin
                    if (r_kind == KIND_LOOKUP) begin
                        r_res_found <= w_pool_value_q;
                    end
                end else if (w_link_empty) begin
                    r_res_status <= ST_MISS;
                end else begin
                    r_prev       <= r_cur;
                    r_prev_valid <= 1'b1;
                    r_cur        <= w_pool_link_q[PW-1:0];
                end
            end

            if (w_rsp_load) begin
                r_out_valid <= 1'b1;
                r_status    <= r_res_status;
                r_found     <= r_res_found;
                r_op_live   <= 1'b0;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.status      = r_status;
    assign o_rsp.found_value = r_found;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `PHM_ASSERT_IMPL(a_fill_bound, i_clk, i_rst_n, 1'b1, r_fill <= EMPTY, "pool fill beyond pool size")
    `PHM_ASSERT_IMPL(a_clear_no_pool_write, i_clk, i_rst_n, r_state == S_CLEAR, !w_pool_we.fields && !w_pool_we.link, "pool written during clear sweep")
    `PHM_ASSERT_IMPL(a_hash_done_in_hash, i_clk, i_rst_n, w_hash_done, r_state == S_HASH, "hash finished outside hash state")
    `PHM_ASSERT_IMPL(a_miss_zero_value, i_clk, i_rst_n, o_rsp.valid && (o_rsp.status != ST_OK), o_rsp.found_value == '0, "non-zero value on miss or full")
    `PHM_ASSERT_NEXT(a_insert_fill, i_clk, i_rst_n, (r_state == S_LINK) && (r_kind == KIND_INSERT), r_fill == LW'($past(r_fill) + LW'(1)), "insert did not advance pool fill")

endmodule

`default_nettype wire

FILE: tb/phm_table_mirror_pkg.sv
// ----------------------------------------------------------------------------
// phm_table_mirror_pkg
// Software copy of the process-id hash map that predicts every response and
// checks the responses of the block against those predictions in order.
// ----------------------------------------------------------------------------
`default_nettype none

package phm_table_mirror_pkg;

    import phm_pkg::*;

    localparam int BUCKETS      = 256;
    localparam int POOL_ENTRIES = 256;
    localparam int NO_SLOT      = POOL_ENTRIES;
    localparam int PRINT_CAP    = 40;

    typedef struct packed {
        t_status              status;
        logic [VALUE_W-1:0]   found_value;
    } t_answer;

    class phm_table_mirror;

        int unsigned          chain_head [BUCKETS];
        logic [KEY_W-1:0]     slot_key   [POOL_ENTRIES];
        logic [VALUE_W-1:0]   slot_value [POOL_ENTRIES];
        int unsigned          slot_next  [POOL_ENTRIES];
        int unsigned          slots_used;
        t_answer              answers_due [$];
        int unsigned          mismatches;

        function new();
            foreach (slot_key[i]) begin
                slot_key[i]   = '0;
                slot_value[i] = '0;
                slot_next[i]  = 0;
            end
            mismatches = 0;
            clear_table();
        endfunction

        function void clear_table();
            foreach (chain_head[i]) begin
                chain_head[i] = NO_SLOT;
            end
            slots_used = 0;
        endfunction

        // Only the low bits of the wrapped product select the bucket.
        function int unsigned bucket_index(logic [KEY_W-1:0] key);
            logic [HASH_W-1:0] prod;
            prod = HASH_MULT * HASH_W'(key);
            return prod % BUCKETS;
        endfunction

        function int unsigned pending();
            return answers_due.size();
        endfunction

        function void note_request(t_kind kind, logic [KEY_W-1:0] key,
                                   logic [VALUE_W-1:0] value);
            t_answer     ans;
            int unsigned bucket;
            int unsigned prev;
            int unsigned cur;
            int unsigned steps;
            ans.status      = ST_OK;
            ans.found_value = '0;
            bucket          = bucket_index(key);
            case (kind)
                KIND_CLEAR: begin
                    clear_table();
                end
                KIND_INSERT: begin
                    if (slots_used >= POOL_ENTRIES) begin
                        ans.status = ST_FULL;
                    end else begin
                        slot_key[slots_used]   = key;
                        slot_value[slots_used] = value;
                        slot_next[slots_used]  = chain_head[bucket];
                        chain_head[bucket]     = slots_used;
                        slots_used++;
                    end
                end
                default: begin
                    ans.status = ST_MISS;
                    prev       = NO_SLOT;
                    cur        = chain_head[bucket];
                    steps      = 0;
                    while (cur < POOL_ENTRIES && steps < POOL_ENTRIES) begin
                        if (slot_key[cur] == key) begin
                            ans.status = ST_OK;
                            if (kind == KIND_LOOKUP) begin
                                ans.found_value = slot_value[cur];
                            end else if (prev == NO_SLOT) begin
                                chain_head[bucket] = slot_next[cur];
                            end else begin
                                slot_next[prev] = slot_next[cur];
                            end
                            break;
                        end
                        prev = cur;
                        cur  = slot_next[cur];
                        steps++;
                    end
                end
            endcase
            answers_due.push_back(ans);
        endfunction

        task report_mismatch(string what);
            mismatches++;
            if (mismatches <= PRINT_CAP) begin
                $display("tb_top: mismatch at %0t ns: %s", $realtime, what);
            end
        endtask

        task check_answer(logic [STATUS_W-1:0] status, logic [VALUE_W-1:0] found_value);
            t_answer ans;
            if (answers_due.size() == 0) begin
                report_mismatch("response beat with no request outstanding");
            end else begin
                ans = answers_due.pop_front();
                if (status !== ans.status) begin
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              status, ans.status));
                end
                if (found_value !== ans.found_value) begin
                    report_mismatch($sformatf("found_value %0d, expected %0d",
                                              found_value, ans.found_value));
                end
            end
        endtask

    endclass

endpackage

`default_nettype wire

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench of the process-id chained hash map. Requests are driven
// in random bursts, responses are taken with a random stall pattern, and each
// response beat is compared with a software copy of the table.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import phm_pkg::*;
    import phm_table_mirror_pkg::*;

    // The slowest lookup walks a whole pool's worth of chain after the hash,
    // and a clear sweeps every bucket, so the quiet stretch at the end is long
    // enough for either.
    localparam int SETTLE_CYCLES   = 400;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int CYCLE_LIMIT     = 2_000_000;
    localparam int TOTAL_OPS       = 1250;
    localparam int LIVE_KEYS_MAX   = 48;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    phm_req_if req_bus ();
    phm_rsp_if rsp_bus ();

    pid_chained_hash_map #(
        .BUCKETS      (BUCKETS),
        .POOL_ENTRIES (POOL_ENTRIES)
    ) i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_bus),
        .o_rsp   (rsp_bus)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    phm_table_mirror mirror = new();

    // Keys that have been inserted since the last clear; lookups and removes
    // draw from these so that most of them actually find something.
    logic [KEY_W-1:0] live_keys [$];
    int unsigned      burst_left = 0;
    int unsigned      ops_sent = 0;
    bit               hold_off_asked = 1'b0;

    // Every input is at a known value from time zero.
    initial begin
        req_bus.valid = 1'b0;
        req_bus.kind  = KIND_LOOKUP;
        req_bus.key   = '0;
        req_bus.value = '0;
        rsp_bus.ready = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------------

    // Offers one request beat and returns once it has been accepted. Bursts of
    // random length are separated by random gaps with valid low; now and again
    // a long burst gives a stretch with no idling at all.
    task automatic offer_op(input t_kind kind, input logic [KEY_W-1:0] key,
                            input logic [VALUE_W-1:0] value);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                                      : $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
                @(negedge clk);
                req_bus.valid = 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        req_bus.valid = 1'b1;
        req_bus.kind  = kind;
        req_bus.key   = key;
        req_bus.value = value;
        forever begin
            @(posedge clk);
            if (req_bus.ready) break;
        end
        mirror.note_request(kind, key, value);
        ops_sent++;
        if (kind == KIND_CLEAR) begin
            live_keys.delete();
        end else if (kind == KIND_INSERT) begin
            live_keys.push_back(key);
            if (live_keys.size() > LIVE_KEYS_MAX) void'(live_keys.pop_front());
        end
    endtask

    // The sender stops offering until every outstanding response has come.
    task automatic wait_for_answers();
        @(negedge clk);
        req_bus.valid = 1'b0;
        while (mirror.pending() != 0) @(posedge clk);
    endtask

    // Picks a key: in up to familiar_pct percent of calls one inserted since the last clear (or a key in
    // the same bucket as one, since only the low eight bits pick the bucket), otherwise
    // a fresh 23-bit key, with the two extremes turning up now and then.
    function automatic logic [KEY_W-1:0] pick_key(int unsigned familiar_pct);
        logic [KEY_W-1:0] k;
        int unsigned      r;
        r = $urandom_range(0, 99);
        if (live_keys.size() != 0 && r < familiar_pct) begin
            k = live_keys[$urandom_range(0, live_keys.size() - 1)];
            if ($urandom_range(0, 3) == 0) k[KEY_W-1:8] = (KEY_W-8)'($urandom());
        end else begin
            case ($urandom_range(0, 9))
                0:       k = '0;
                1:       k = '1;
                default: k = KEY_W'($urandom());
            endcase
        end
        return k;
    endfunction

    // A random mix of operations with the occasional clear.
    task automatic run_mixed(input int count);
        int unsigned r;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(0, 99);
            if (r < 2) begin
                offer_op(KIND_CLEAR, KEY_W'($urandom()), VALUE_W'($urandom()));
            end else if (r < 45) begin
                offer_op(KIND_INSERT, pick_key(50), VALUE_W'($urandom()));
            end else if (r < 75) begin
                offer_op(KIND_LOOKUP, pick_key(80), VALUE_W'($urandom()));
            end else begin
                offer_op(KIND_REMOVE, pick_key(75), VALUE_W'($urandom()));
            end
        end
    endtask

    // Fills the pool to the brim, piling the keys into a handful of buckets so
    // that chains grow long, then keeps inserting so that the pool-full answer
    // comes up, with removes in between that must not free any slot.
    task automatic run_pool_fill();
        logic [KEY_W-1:0] k;
        offer_op(KIND_CLEAR, '0, '0);
        while (mirror.slots_used < POOL_ENTRIES) begin
            if ($urandom_range(0, 3) == 0) begin
                offer_op(KIND_LOOKUP, pick_key(85), VALUE_W'($urandom()));
            end else begin
                k = KEY_W'($urandom());
                case ($urandom_range(0, 3))
                    0:       k[7:0] = 8'h00;
                    1:       k[7:0] = 8'h13;
                    2:       k[7:0] = 8'hFF;
                    default: ;
                endcase
                offer_op(KIND_INSERT, k, VALUE_W'($urandom()));
            end
        end
        for (int i = 0; i < 40; i++) begin
            case ($urandom_range(0, 2))
                0:       offer_op(KIND_INSERT, pick_key(30), VALUE_W'($urandom()));
                1:       offer_op(KIND_REMOVE, pick_key(80), VALUE_W'($urandom()));
                default: offer_op(KIND_LOOKUP, pick_key(80), VALUE_W'($urandom()));
            endcase
        end
        offer_op(KIND_CLEAR, KEY_W'($urandom()), VALUE_W'($urandom()));
        offer_op(KIND_INSERT, 23'h00_1234, 8'h77);
        offer_op(KIND_LOOKUP, 23'h00_1234, 8'h00);
    endtask

    // Short directed opening: extreme keys and values, every operation, a
    // chain of keys sharing bucket zero with a remove from its middle and its
    // head, a duplicate insert that shadows the older entry and is uncovered
    // again by a remove, and removes and lookups of absent keys.
    task automatic run_directed();
        offer_op(KIND_CLEAR,  23'h7F_FFFF, 8'hFF);
        offer_op(KIND_LOOKUP, 23'h00_0000, 8'h00);
        offer_op(KIND_REMOVE, 23'h00_0000, 8'h00);
        offer_op(KIND_INSERT, 23'h00_0000, 8'h00);
        offer_op(KIND_INSERT, 23'h7F_FFFF, 8'hFF);
        offer_op(KIND_INSERT, 23'h00_0100, 8'hA5);
        offer_op(KIND_INSERT, 23'h00_0200, 8'h5A);
        offer_op(KIND_LOOKUP, 23'h00_0000, 8'h00);
        offer_op(KIND_LOOKUP, 23'h7F_FFFF, 8'h00);
        offer_op(KIND_LOOKUP, 23'h00_0100, 8'h00);
        offer_op(KIND_REMOVE, 23'h00_0100, 8'h00);
        offer_op(KIND_LOOKUP, 23'h00_0100, 8'h00);
        offer_op(KIND_INSERT, 23'h00_0000, 8'h33);
        offer_op(KIND_LOOKUP, 23'h00_0000, 8'h00);
        offer_op(KIND_REMOVE, 23'h00_0000, 8'h00);
        offer_op(KIND_LOOKUP, 23'h00_0000, 8'h00);
        offer_op(KIND_REMOVE, 23'h00_0000, 8'h00);
        offer_op(KIND_REMOVE, 23'h00_0000, 8'h00);
        offer_op(KIND_REMOVE, 23'h00_0200, 8'h00);
        offer_op(KIND_LOOKUP, 23'h00_0400, 8'h00);
        offer_op(KIND_INSERT, 23'h55_5555, 8'h55);
        offer_op(KIND_INSERT, 23'h2A_AAAA, 8'hAA);
        offer_op(KIND_LOOKUP, 23'h55_5555, 8'h00);
        offer_op(KIND_LOOKUP, 23'h2A_AAAA, 8'h00);
        offer_op(KIND_CLEAR,  23'h00_0000, 8'h00);
        offer_op(KIND_LOOKUP, 23'h7F_FFFF, 8'h00);
    endtask

    // ------------------------------------------------------------------------
    // Response side
    // ------------------------------------------------------------------------

    // The receiver draws a new stall rate for each stretch of random length, including
    // stretches where it never stalls. When asked, it holds ready low for a
    // long stretch counted down in hold_left, so that the block backs up and stops
    // taking requests while the sender keeps offering.
    initial begin : response_side
        int unsigned hold_left;
        int unsigned mode_left;
        int unsigned stall_pct;
        hold_left = 0;
        mode_left = 0;
        stall_pct = 0;
        forever begin
            @(negedge clk);
            if (hold_off_asked) begin
                hold_off_asked = 1'b0;
                hold_left      = HOLD_OFF_CYCLES;
            end
            if (mode_left == 0) begin
                mode_left = $urandom_range(16, 128);
                case ($urandom_range(0, 4))
                    0, 1:    stall_pct = 0;
                    2:       stall_pct = 25;
                    3:       stall_pct = 50;
                    default: stall_pct = 90;
                endcase
            end
            mode_left--;
            if (hold_left != 0) begin
                hold_left--;
                rsp_bus.ready = 1'b0;
            end else begin
                rsp_bus.ready = ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    // Each accepted response beat is checked against the oldest prediction.
    always @(posedge clk) begin
        if (rst_n && rsp_bus.valid && rsp_bus.ready) begin
            mirror.check_answer(rsp_bus.status, rsp_bus.found_value);
        end
    end

    // A hung block or a lost response ends the run here.
    initial begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("tb_top: FAIL");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin : main_sequence
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        run_directed();
        wait_for_answers();

        run_mixed(200);
        // Long receiver hold-off while requests keep coming.
        hold_off_asked = 1'b1;
        run_mixed(250);
        wait_for_answers();

        hold_off_asked = 1'b1;
        run_pool_fill();
        wait_for_answers();

        if (ops_sent < TOTAL_OPS) run_mixed(TOTAL_OPS - ops_sent);

        wait_for_answers();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mirror.mismatches == 0 && mirror.pending() == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire
